[rtl/stx_pkg.sv]
// ----------------------------------------------------------------------------
// stx_pkg
// Shared constants, types and helpers for the simplex tableau solver.
// ----------------------------------------------------------------------------
package stx_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W    = $clog2(MAX_COLS + 1);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [MAX_ROWS-1:0] col_t;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_READ      = 3'd1;
  localparam logic [2:0] ST_OPTIMAL   = 3'd2;
  localparam logic [2:0] ST_UNBOUNDED = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;

  localparam logic [1:0] REG_ROWS     = 2'd0;
  localparam logic [1:0] REG_COLS     = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;

  function automatic word_t sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    word_t r;
    hi = {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = {{(DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > hi) begin
      r = hi[DATA_W-1:0];
    end else if (v < lo) begin
      r = lo[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/stx_cell.sv]
// ----------------------------------------------------------------------------
// stx_cell
// One link of the column ring: holds one tableau column, shifts it on.
// ----------------------------------------------------------------------------
module stx_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  stx_pkg::col_t             col_in,
  input  logic                      wr_en,
  input  logic [stx_pkg::ROW_W-1:0] wr_row,
  input  stx_pkg::word_t            wr_data,
  output stx_pkg::col_t             col_q
);
  import stx_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end else if (wr_en) begin
      col_q[wr_row] <= wr_data;
    end
  end

endmodule

[rtl/stx_div.sv]
// ----------------------------------------------------------------------------
// stx_div
// Bit-serial fixed-point divider, truncating toward zero, saturating.
// ----------------------------------------------------------------------------
module stx_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  stx_pkg::word_t x,
  input  stx_pkg::word_t p,
  output logic           done,
  output stx_pkg::word_t q
);
  import stx_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DATA_W-1:0] rem;
  logic [DIV_W-1:0]  dq;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] t;
  logic              ge;
  logic [DIV_W-1:0]  pos_max;
  logic [DIV_W-1:0]  neg_max;

  assign mag     = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  assign t       = {rem[DATA_W-2:0], dq[DIV_W-1]};
  assign ge      = t >= dvs;
  assign pos_max = DIV_W'({1'b0, {(DATA_W-1){1'b1}}});
  assign neg_max = DIV_W'({1'b1, {(DATA_W-1){1'b0}}});

  always_comb begin
    if (!neg) begin
      q = (dq > pos_max) ? word_t'(pos_max[DATA_W-1:0]) : word_t'(dq[DATA_W-1:0]);
    end else begin
      q = (dq > neg_max) ? word_t'(neg_max[DATA_W-1:0]) : word_t'(-dq[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
        rem  <= '0;
        dq   <= {mag, {FRAC_BITS{1'b0}}};
        dvs  <= DATA_W'(p);
        neg  <= x[DATA_W-1];
      end else if (busy) begin
        rem <= ge ? (t - dvs) : t;
        dq  <= {dq[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/simplex_tableau_solver.sv]
// ----------------------------------------------------------------------------
// simplex_tableau_solver
// Dantzig simplex on a Q16.16 tableau held in a ring of column cells.
// ----------------------------------------------------------------------------
// The tableau lives in a ring of 32 column cells; during a solve the ring
// rotates one column per cycle past a single processing head, except while
// it is held for the ratio test or a divide and multiply, and always returns
// home. Write and read transactions are served only while idle. A solve
// holds off input until it reports; each pivot runs a column scan, a ratio
// test over the used rows, and per used column a bit-serial divide, multiply
// and subtract, while an unused column just shifts on; a solve ends with a
// closing scan (and ratio test unless the tableau is optimal).
// ----------------------------------------------------------------------------
module simplex_tableau_solver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [3:0]  row,
  input  logic [4:0]  col,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_value,
  output logic [2:0]  status,
  output logic [15:0] pivots_done,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import stx_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FINDC = 4'd1;
  localparam logic [3:0] S_CHKC  = 4'd2;
  localparam logic [3:0] S_RATIO = 4'd3;
  localparam logic [3:0] S_CHKR  = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;

  logic [3:0]        state;
  logic [RCNT_W-1:0] rows;
  logic [CCNT_W-1:0] cols;
  logic [15:0]       max_iter;
  logic [15:0]       count;
  logic [COL_W-1:0]  j;
  logic [ROW_W-1:0]  i;
  logic              ph;
  logic              found;
  word_t             best;
  col_t              pcol;
  col_t              rhs;
  logic              found_r;
  logic [ROW_W-1:0]  pr;
  word_t             ab;
  word_t             rb;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  word_t             pe;
  word_t             nval;
  logic signed [PROD_W-1:0] prod [MAX_ROWS];

  col_t              cells_q [MAX_COLS];
  col_t              head;
  col_t              tail;
  logic              shift;
  logic              used;
  logic              last;
  logic              accept;
  logic              wr_go;
  logic              div_start;
  logic              div_done;
  word_t             div_q;
  logic [RCNT_W-1:0] cfg_rows;
  logic [CCNT_W-1:0] cfg_cols;

  assign head      = cells_q[0];
  assign used      = CCNT_W'(j) < cols;
  assign last      = j == COL_W'(MAX_COLS - 1);
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign wr_go     = accept && (cmd == CMD_WRITE);
  assign shift     = (state == S_FINDC) || (state == S_SUB) || ((state == S_HEAD) && !used);
  assign div_start = (state == S_HEAD) && used;

  always_comb begin
    logic signed [PROD_W-1:0] d;
    d = '0;
    tail = head;
    if (state == S_SUB) begin
      for (int k = 0; k < MAX_ROWS; k++) begin
        d = $signed({{DATA_W{head[k][DATA_W-1]}}, head[k]}) - (prod[k] >>> FRAC_BITS);
        if (ROW_W'(k) == pr) begin
          tail[k] = nval;
        end else if (RCNT_W'(k) < rows) begin
          tail[k] = sat_word(d);
        end
      end
    end
  end

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_ring
    col_t nb;
    if (k == MAX_COLS - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_link
      assign nb = cells_q[k+1];
    end
    stx_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (nb),
      .wr_en   (wr_go && (col == COL_W'(k))),
      .wr_row  (row),
      .wr_data (value),
      .col_q   (cells_q[k])
    );
  end

  stx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (head[pr]),
    .p     (pe),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    cfg_rows = cfg_data[RCNT_W-1:0];
    if (cfg_rows == '0) cfg_rows = RCNT_W'(1);
    if (cfg_rows > RCNT_W'(MAX_ROWS)) cfg_rows = RCNT_W'(MAX_ROWS);
    cfg_cols = cfg_data[CCNT_W-1:0];
    if (cfg_cols < CCNT_W'(2)) cfg_cols = CCNT_W'(2);
    if (cfg_cols > CCNT_W'(MAX_COLS)) cfg_cols = CCNT_W'(MAX_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= RCNT_W'(MAX_ROWS);
      cols      <= CCNT_W'(MAX_COLS);
      max_iter  <= 16'd1024;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ROWS:     rows     <= cfg_rows;
        REG_COLS:     cols     <= cfg_cols;
        REG_MAX_ITER: max_iter <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            read_value  <= '0;
            pivots_done <= '0;
            status      <= ST_WRITTEN;
            case (cmd)
              CMD_SOLVE: begin
                count <= '0;
                found <= 1'b0;
                j     <= '0;
                state <= S_FINDC;
              end
              CMD_READ: begin
                out_valid  <= 1'b1;
                read_value <= cells_q[col][row];
                status     <= ST_READ;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_FINDC: begin
          if ((CCNT_W'(j) < cols - 1'b1) && head[0] < 0 && (!found || head[0] < best)) begin
            best  <= head[0];
            pcol  <= head;
            found <= 1'b1;
          end
          if (CCNT_W'(j) == cols - 1'b1) rhs <= head;
          j <= j + 1'b1;
          if (last) state <= S_CHKC;
        end
        S_CHKC: begin
          if (!found) begin
            out_valid   <= 1'b1;
            status      <= ST_OPTIMAL;
            pivots_done <= count;
            state       <= S_IDLE;
          end else begin
            i       <= '0;
            ph      <= 1'b0;
            found_r <= 1'b0;
            state   <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (!ph) begin
            p1 <= rhs[i] * ab;
            p2 <= rb * pcol[i];
            ph <= 1'b1;
          end else begin
            if (pcol[i] > 0 && (!found_r || p1 < p2)) begin
              pr      <= i;
              ab      <= pcol[i];
              rb      <= rhs[i];
              found_r <= 1'b1;
            end
            ph <= 1'b0;
            if (RCNT_W'(i) == rows - 1'b1) state <= S_CHKR;
            else i <= i + 1'b1;
          end
        end
        S_CHKR: begin
          if (!found_r || count >= max_iter) begin
            out_valid   <= 1'b1;
            status      <= found_r ? ST_LIMIT : ST_UNBOUNDED;
            pivots_done <= count;
            state       <= S_IDLE;
          end else begin
            pe    <= ab;
            j     <= '0;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (used) begin
            state <= S_DIV;
          end else begin
            j <= j + 1'b1;
            if (last) begin
              count <= count + 1'b1;
              found <= 1'b0;
              state <= S_FINDC;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            nval  <= div_q;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          for (int k = 0; k < MAX_ROWS; k++) prod[k] <= pcol[k] * nval;
          state <= S_SUB;
        end
        S_SUB: begin
          j <= j + 1'b1;
          if (last) begin
            count <= count + 1'b1;
            found <= 1'b0;
            state <= S_FINDC;
          end else begin
            state <= S_HEAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
